@@ hdl/msc_pkg.sv @@
package msc_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned MOD_W   = 4;
  localparam int unsigned STATE_W = 3;

  // Line states of the MOSI protocol, including the transient ones.
  typedef enum logic [STATE_W-1:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_M  = 3'd2,
    ST_O  = 3'd3,
    ST_IM = 3'd4,
    ST_IS = 3'd5,
    ST_SM = 3'd6,
    ST_OM = 3'd7
  } line_state_e;

  // Command codes; the remaining encodings are illegal.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_STORE = 3'd1,
    CMD_GETS  = 3'd2,
    CMD_GETM  = 3'd3,
    CMD_DATA  = 3'd4
  } cmd_e;

  // Controller phase: table clearing after reset, then normal operation.
  typedef enum logic {
    CTRL_CLEAR,
    CTRL_RUN
  } ctrl_e;

  typedef struct packed {
    logic        gets;
    logic        getm;
    logic        dproc;
    logic        dbus;
    logic        shared;
    logic        miss;
    logic        bad;
    line_state_e nst;
  } step_t;

  // Protocol actions and next state for one command applied to one line.
  function automatic step_t msc_next(line_state_e st, logic [CMD_W-1:0] cmd);
    step_t r;
    r     = '0;
    r.nst = st;
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        case (st)
          ST_I: begin
            r.miss = 1'b1;
            if (cmd == CMD_STORE) begin
              r.getm = 1'b1;
              r.nst  = ST_IM;
            end else begin
              r.gets = 1'b1;
              r.nst  = ST_IS;
            end
          end
          ST_S, ST_O: begin
            if (cmd == CMD_STORE) begin
              r.getm = 1'b1;
              r.miss = 1'b1;
              r.nst  = (st == ST_S) ? ST_SM : ST_OM;
            end else begin
              r.dproc = 1'b1;
            end
          end
          ST_M: r.dproc = 1'b1;
          default: ;
        endcase
      end
      CMD_GETS, CMD_GETM, CMD_DATA: begin
        case (st)
          ST_S: begin
            if (cmd == CMD_GETS) begin
              r.shared = 1'b1;
            end else if (cmd == CMD_GETM) begin
              r.nst = ST_I;
            end
          end
          ST_M, ST_O: begin
            if (cmd == CMD_GETS) begin
              r.shared = 1'b1;
              r.dbus   = 1'b1;
              r.nst    = ST_O;
            end else if (cmd == CMD_GETM) begin
              r.dbus = 1'b1;
              r.nst  = ST_I;
            end
          end
          ST_IM, ST_IS: begin
            if (cmd == CMD_DATA) begin
              r.dproc = 1'b1;
              r.nst   = (st == ST_IM) ? ST_M : ST_S;
            end
          end
          ST_SM: begin
            if (cmd == CMD_GETS) begin
              r.shared = 1'b1;
            end else if (cmd == CMD_GETM) begin
              r.nst = ST_IM;
            end else begin
              r.dproc = 1'b1;
              r.nst   = ST_M;
            end
          end
          ST_OM: begin
            if (cmd == CMD_GETS) begin
              r.shared = 1'b1;
              r.dbus   = 1'b1;
            end else if (cmd == CMD_GETM) begin
              r.dbus = 1'b1;
              r.nst  = ST_IM;
            end else begin
              r.dproc = 1'b1;
              r.nst   = ST_M;
            end
          end
          default: ;
        endcase
      end
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/msc_req_if.sv @@
interface msc_req_if
  import msc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] line_index;
  logic [ADDR_W-1:0]  line_address;
  logic [MOD_W-1:0]   requester;

  modport source (output valid, command, line_index, line_address, requester,
                  input ready);
  modport sink   (input valid, command, line_index, line_address, requester,
                  output ready);
endinterface

@@ hdl/msc_rsp_if.sv @@
interface msc_rsp_if
  import msc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               issue_gets;
  logic               issue_getm;
  logic               data_to_proc;
  logic               data_on_bus;
  logic               assert_shared;
  logic               miss;
  logic               illegal;
  logic [ADDR_W-1:0]  out_address;
  logic [MOD_W-1:0]   data_dest;
  logic [STATE_W-1:0] new_state;

  modport source (output valid, issue_gets, issue_getm, data_to_proc, data_on_bus,
                  assert_shared, miss, illegal, out_address, data_dest, new_state,
                  input ready);
  modport sink   (input valid, issue_gets, issue_getm, data_to_proc, data_on_bus,
                  assert_shared, miss, illegal, out_address, data_dest, new_state,
                  output ready);
endinterface

@@ hdl/msc_ram.sv @@
module msc_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mosi_snoop_coherence_controller_top.sv @@
// MOSI snooping coherence controller.
// The req_i channel carries one transaction per processor request (load,
// store) or snooped bus message (GETS, GETM, data arrival) for one cache
// line. For each accepted transaction exactly one transaction leaves on
// rsp_o: the bus request, data hand-off, shared-line assertion, miss pulse,
// illegal flag and the line's new state.
// The per-line states live in a single-port-write, registered-read RAM.
// A transaction reads its line in the cycle it is accepted; from the lookup
// stage it then evaluates the protocol, writes the new state back and loads
// the output register as soon as the output register can take it.
// A transaction to the line that is being written back in its accept cycle
// takes the new state from a forwarding register, so one transaction per
// cycle is sustained even on same-line hits while rsp_o does not stall.
// After reset the table is swept to state I, one entry per cycle, over all
// min(LINES, 1024) entries; req_i.ready stays low during the sweep.
// When the receiver stalls, the output register holds its transaction and
// the lookup stage holds one more, so at most two transactions are in
// flight; req_i.ready drops until the output register drains.
module mosi_snoop_coherence_controller_top
  import msc_pkg::*;
#(
  parameter int unsigned LINES     = 1024,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msc_req_if.sink   req_i,
  msc_rsp_if.source rsp_o
);

  // Only the entries that a 10-bit index can reach are stored.
  localparam int unsigned DEPTH = (LINES < (1 << INDEX_W)) ? LINES : (1 << INDEX_W);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  // Clearing sequencer after reset.
  ctrl_e         ctrl_q, ctrl_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clearing;

  // Lookup stage: transaction whose state read is in flight.
  logic               s1_valid_q, s1_valid_d;
  logic [CMD_W-1:0]   s1_cmd_q;
  logic [INDEX_W-1:0] s1_idx_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [MOD_W-1:0]   s1_req_q;
  logic               s1_inrange_q;
  logic               fwd_q, fwd_d;
  line_state_e        fwd_state_q;

  // Output register.
  logic               rsp_valid_q, rsp_valid_d;
  step_t              rsp_step_q, rsp_step_d;
  logic [ADDR_W-1:0]  rsp_addr_q, rsp_addr_d;
  logic [MOD_W-1:0]   rsp_dest_q, rsp_dest_d;

  logic               advance;
  logic               accept;
  logic               wb_en;
  logic [STATE_W-1:0] rd_data;
  line_state_e        cur_state;
  step_t              step;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [STATE_W-1:0] ram_wdata;

  // Next state of the sequencer.
  always_comb begin
    ctrl_d    = ctrl_q;
    clr_cnt_d = clr_cnt_q;
    case (ctrl_q)
      CTRL_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == CLR_LAST) begin
          ctrl_d = CTRL_RUN;
        end
      end
      CTRL_RUN: ;
      default: ctrl_d = CTRL_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    case (ctrl_q)
      CTRL_CLEAR: clearing = 1'b1;
      CTRL_RUN:   clearing = 1'b0;
      default:    clearing = 1'b1;
    endcase
  end

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !clearing && advance;
  assign accept      = req_i.valid && req_i.ready;

  // Protocol evaluation on the state read from the table, or on the state
  // written back by the previous transaction to the same line.
  assign cur_state = fwd_q ? fwd_state_q : line_state_e'(rd_data);

  always_comb begin
    step = msc_next(cur_state, s1_cmd_q);
    if (!s1_inrange_q) begin
      step     = '0;
      step.bad = 1'b1;
      step.nst = ST_I;
    end
  end

  assign wb_en = s1_valid_q && advance && s1_inrange_q;
  assign fwd_d = wb_en && (s1_idx_q == req_i.line_index);

  always_comb begin
    s1_valid_d  = advance ? accept : s1_valid_q;
    rsp_valid_d = advance ? s1_valid_q : rsp_valid_q;
    rsp_step_d  = step;
    rsp_addr_d  = (step.gets || step.getm || step.dproc || step.dbus)
                  ? (s1_addr_q & ADDR_MASK) : '0;
    rsp_dest_d  = step.dbus ? s1_req_q : '0;
  end

  // Table write port: clearing sweep or write-back.
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = ST_I;
    end else begin
      ram_we    = wb_en;
      ram_waddr = s1_idx_q[AW-1:0];
      ram_wdata = step.nst;
    end
  end

  msc_ram #(
    .WIDTH(STATE_W),
    .DEPTH(DEPTH)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(req_i.line_index[AW-1:0]),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CTRL_CLEAR;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= req_i.command;
      s1_idx_q     <= req_i.line_index;
      s1_addr_q    <= req_i.line_address;
      s1_req_q     <= req_i.requester;
      s1_inrange_q <= ({7'd0, req_i.line_index} < 17'(LINES));
      fwd_state_q  <= step.nst;
    end
    if (advance && s1_valid_q) begin
      rsp_step_q <= rsp_step_d;
      rsp_addr_q <= rsp_addr_d;
      rsp_dest_q <= rsp_dest_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.issue_gets    = rsp_step_q.gets;
  assign rsp_o.issue_getm    = rsp_step_q.getm;
  assign rsp_o.data_to_proc  = rsp_step_q.dproc;
  assign rsp_o.data_on_bus   = rsp_step_q.dbus;
  assign rsp_o.assert_shared = rsp_step_q.shared;
  assign rsp_o.miss          = rsp_step_q.miss;
  assign rsp_o.illegal       = rsp_step_q.bad;
  assign rsp_o.out_address   = rsp_addr_q;
  assign rsp_o.data_dest     = rsp_dest_q;
  assign rsp_o.new_state     = rsp_step_q.nst;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the MOSI snooping coherence controller.
// A driver process offers request transactions from a queue that the main
// initial block fills; a monitor process accepts response transactions and
// compares them with the expected responses. The expected responses come
// from a line-state model that is updated for every request transaction the
// controller accepts.
module tb;
  import msc_pkg::*;

  localparam int unsigned NUM_LINES    = 1024;
  localparam int unsigned DIRECTED_CNT = 26;
  localparam int unsigned RANDOM_CNT   = 1300;
  localparam int unsigned HOT_LINES    = 8;
  localparam int unsigned HOT_W        = $clog2(HOT_LINES);
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned TAIL_CYCLES  = 8;

  // One request transaction. The drain flag makes the driver hold this
  // transaction back until every outstanding response has arrived.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] line_index;
    logic [ADDR_W-1:0]  line_address;
    logic [MOD_W-1:0]   requester;
    logic               drain;
  } coh_req_t;

  // The response that one request transaction is expected to produce.
  typedef struct packed {
    logic               gets;
    logic               getm;
    logic               dproc;
    logic               dbus;
    logic               shared;
    logic               miss;
    logic               illegal;
    logic [ADDR_W-1:0]  address;
    logic [MOD_W-1:0]   dest;
    line_state_e        nst;
  } coh_rsp_t;

  logic clk_i;
  logic rst_ni;

  msc_req_if req_if ();
  msc_rsp_if rsp_if ();

  mosi_snoop_coherence_controller_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Line states as the testbench tracks them.
  line_state_e line_tbl [NUM_LINES];

  coh_req_t    pending_q [$];
  coh_rsp_t    expected_q [$];
  coh_req_t    offered_req;
  bit          offering;
  int unsigned sent_cnt;
  int unsigned rcvd_cnt;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned err_cnt;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Applies one request transaction to the tracked line state and returns
  // the response that the protocol calls for.
  function automatic coh_rsp_t apply_coherence(coh_req_t t);
    coh_rsp_t    r;
    line_state_e cur;
    r     = '0;
    cur   = line_tbl[t.line_index];
    r.nst = cur;
    if (t.command > CMD_DATA) begin
      // Unknown encodings only raise the error flag; the line keeps its state.
      r.illegal = 1'b1;
    end else begin
      case (cmd_e'(t.command))
        CMD_LOAD: begin
          case (cur)
            ST_I: begin
              r.gets = 1'b1;
              r.miss = 1'b1;
              r.nst  = ST_IS;
            end
            ST_S, ST_M, ST_O: r.dproc = 1'b1;
            default: ;
          endcase
        end
        CMD_STORE: begin
          case (cur)
            ST_I: begin
              r.getm = 1'b1;
              r.miss = 1'b1;
              r.nst  = ST_IM;
            end
            ST_S: begin
              r.getm = 1'b1;
              r.miss = 1'b1;
              r.nst  = ST_SM;
            end
            ST_O: begin
              r.getm = 1'b1;
              r.miss = 1'b1;
              r.nst  = ST_OM;
            end
            ST_M: r.dproc = 1'b1;
            default: ;
          endcase
        end
        CMD_GETS: begin
          case (cur)
            ST_S, ST_SM: r.shared = 1'b1;
            ST_M, ST_O: begin
              r.shared = 1'b1;
              r.dbus   = 1'b1;
              r.nst    = ST_O;
            end
            ST_OM: begin
              r.shared = 1'b1;
              r.dbus   = 1'b1;
            end
            default: ;
          endcase
        end
        CMD_GETM: begin
          case (cur)
            ST_S: r.nst = ST_I;
            ST_M, ST_O: begin
              r.dbus = 1'b1;
              r.nst  = ST_I;
            end
            ST_SM: r.nst = ST_IM;
            ST_OM: begin
              r.dbus = 1'b1;
              r.nst  = ST_IM;
            end
            default: ;
          endcase
        end
        CMD_DATA: begin
          case (cur)
            ST_IM, ST_SM, ST_OM: begin
              r.dproc = 1'b1;
              r.nst   = ST_M;
            end
            ST_IS: begin
              r.dproc = 1'b1;
              r.nst   = ST_S;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    line_tbl[t.line_index] = r.nst;
    if (r.gets || r.getm || r.dproc || r.dbus) begin
      r.address = t.line_address;
    end
    if (r.dbus) begin
      r.dest = t.requester;
    end
    return r;
  endfunction

  task automatic queue_req(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                           logic [ADDR_W-1:0] addr, logic [MOD_W-1:0] src,
                           logic drain = 1'b0);
    coh_req_t t;
    t.command      = cmd;
    t.line_index   = idx;
    t.line_address = addr;
    t.requester    = src;
    t.drain        = drain;
    pending_q.push_back(t);
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] exp_v,
                             logic [ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Driver. Request transactions are offered after random gaps, except in a
  // stretch of back-to-back traffic. Valid is written once per edge, so a
  // transaction that follows directly keeps valid high.
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(apply_coherence(offered_req));
        sent_cnt++;
        offering = 1'b0;
        send_gap = (sent_cnt >= 550 && sent_cnt < 750) ? 0 : $urandom_range(0, 3);
      end
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && expected_q.size() != 0)) begin
          offered_req          = pending_q.pop_front();
          offering             = 1'b1;
          req_if.command      <= offered_req.command;
          req_if.line_index   <= offered_req.line_index;
          req_if.line_address <= offered_req.line_address;
          req_if.requester    <= offered_req.requester;
        end
      end
      req_if.valid <= offering;
    end
  end

  // Monitor. Ready drops for a random gap after each response, except in a
  // stretch with no stalls. Twice the receiver holds off for a long time so
  // that the controller fills up and pushes back on its request channel.
  always @(posedge clk_i) begin : monitor
    coh_rsp_t exp_r;
    logic     rdy;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          err_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("issue_gets",    ADDR_W'(exp_r.gets),    ADDR_W'(rsp_if.issue_gets));
          check_field("issue_getm",    ADDR_W'(exp_r.getm),    ADDR_W'(rsp_if.issue_getm));
          check_field("data_to_proc",  ADDR_W'(exp_r.dproc),   ADDR_W'(rsp_if.data_to_proc));
          check_field("data_on_bus",   ADDR_W'(exp_r.dbus),    ADDR_W'(rsp_if.data_on_bus));
          check_field("assert_shared", ADDR_W'(exp_r.shared),
                      ADDR_W'(rsp_if.assert_shared));
          check_field("miss",          ADDR_W'(exp_r.miss),    ADDR_W'(rsp_if.miss));
          check_field("illegal",       ADDR_W'(exp_r.illegal), ADDR_W'(rsp_if.illegal));
          check_field("out_address",   exp_r.address,          rsp_if.out_address);
          check_field("data_dest",     ADDR_W'(exp_r.dest),    ADDR_W'(rsp_if.data_dest));
          check_field("new_state",     ADDR_W'(exp_r.nst),     ADDR_W'(rsp_if.new_state));
        end
        rcvd_cnt++;
        recv_gap = (rcvd_cnt >= 500 && rcvd_cnt < 700) ? 0 : $urandom_range(0, 3);
        if (rcvd_cnt == 300) begin
          hold_left = 100;
        end else if (rcvd_cnt == 1000) begin
          hold_left = 40;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for
  // too long. The limit covers the table sweep after reset and the long
  // receiver hold-offs several times over.
  always @(posedge clk_i) begin : watchdog
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("mosi_snoop_coherence_controller_top verification failed");
        $finish;
      end
    end
  end

  initial begin : main
    logic [INDEX_W-1:0] hot [HOT_LINES];
    logic [INDEX_W-1:0] ln;
    int unsigned        n;
    int unsigned        k;
    int unsigned        total;

    err_cnt     = 0;
    sent_cnt    = 0;
    rcvd_cnt    = 0;
    send_gap    = 0;
    recv_gap    = 0;
    hold_left   = 0;
    idle_cycles = 0;
    offering    = 1'b0;
    foreach (line_tbl[i]) line_tbl[i] = ST_I;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.command      = '0;
    req_if.line_index   = '0;
    req_if.line_address = '0;
    req_if.requester    = '0;
    rsp_if.ready        = 1'b0;

    // Directed part: walk line 0 through every stable and transient state,
    // with the address and requester at their extremes along the way.
    queue_req(CMD_LOAD,  10'd0, 32'hFFFF_FFFF, 4'd0);  // I -> IS, miss
    queue_req(CMD_LOAD,  10'd0, $urandom, 4'd0);       // ignored while pending
    queue_req(CMD_DATA,  10'd0, 32'h0000_0000, 4'd0);  // IS -> S
    queue_req(CMD_LOAD,  10'd0, $urandom, 4'd0);       // hit in S
    queue_req(CMD_GETS,  10'd0, $urandom, 4'd15);      // S asserts shared
    queue_req(CMD_DATA,  10'd0, $urandom, 4'd3);       // ignored in S
    queue_req(CMD_STORE, 10'd0, $urandom, 4'd0);       // S -> SM, miss
    queue_req(CMD_GETS,  10'd0, $urandom, 4'd7);       // SM asserts shared
    queue_req(CMD_GETM,  10'd0, $urandom, 4'd7);       // SM -> IM
    queue_req(CMD_DATA,  10'd0, $urandom, 4'd0);       // IM -> M
    queue_req(CMD_LOAD,  10'd0, $urandom, 4'd0);       // hit in M
    queue_req(CMD_STORE, 10'd0, $urandom, 4'd0);       // hit in M
    queue_req(CMD_GETS,  10'd0, 32'hFFFF_FFFF, 4'd15); // M -> O, supplies data
    queue_req(CMD_LOAD,  10'd0, $urandom, 4'd0);       // hit in O
    queue_req(CMD_GETS,  10'd0, $urandom, 4'd9);       // O supplies data
    queue_req(CMD_STORE, 10'd0, $urandom, 4'd0);       // O -> OM, miss
    queue_req(CMD_GETS,  10'd0, $urandom, 4'd1);       // OM supplies data
    queue_req(CMD_GETM,  10'd0, $urandom, 4'd15);      // OM -> IM, supplies data
    queue_req(CMD_STORE, 10'd0, $urandom, 4'd0);       // ignored while pending
    queue_req(CMD_DATA,  10'd0, $urandom, 4'd0);       // IM -> M
    queue_req(CMD_GETM,  10'd0, $urandom, 4'd2);       // M -> I, supplies data
    queue_req(CMD_GETS,  10'd0, $urandom, 4'd2);       // snoop ignored in I
    // Unknown command encodings, and the top line of the table.
    queue_req(3'd5, 10'd1023, 32'hFFFF_FFFF, 4'd15);
    queue_req(3'd6, 10'd0,    32'h0000_0000, 4'd0);
    queue_req(3'd7, 10'd1023, $urandom, 4'd15);
    queue_req(CMD_STORE, 10'd1023, 32'hFFFF_FFFF, 4'd15); // I -> IM, miss

    // Random part. Most of it is short coherence sequences on a few hot
    // lines (a processor request, some snoops, the data arrival and a few more
    // requests) so that every state is reached repeatedly; the rest is noise
    // on any line with any command, unknown encodings included. The first
    // random transaction waits for the directed part to drain.
    foreach (hot[i]) hot[i] = INDEX_W'($urandom_range(0, NUM_LINES - 1));
    total = DIRECTED_CNT + RANDOM_CNT;
    while (pending_q.size() < total) begin
      if ($urandom_range(0, 9) < 7) begin
        ln = hot[HOT_W'($urandom_range(0, HOT_LINES - 1))];
        queue_req(CMD_W'($urandom_range(CMD_LOAD, CMD_STORE)), ln, $urandom,
                  MOD_W'($urandom), pending_q.size() == DIRECTED_CNT);
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) begin
          queue_req(CMD_W'($urandom_range(CMD_GETS, CMD_GETM)), ln, $urandom,
                    MOD_W'($urandom));
        end
        queue_req(CMD_DATA, ln, $urandom, MOD_W'($urandom));
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) begin
          queue_req(CMD_W'($urandom_range(CMD_LOAD, CMD_DATA)), ln, $urandom,
                    MOD_W'($urandom));
        end
      end else begin
        queue_req(CMD_W'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, NUM_LINES - 1)),
                  $urandom, MOD_W'($urandom), pending_q.size() == DIRECTED_CNT);
      end
      // Somewhere in the middle the sender pauses until the controller has
      // answered everything it was given.
      if (pending_q.size() >= 700 && pending_q.size() < 705) begin
        pending_q[pending_q.size() - 1].drain = 1'b1;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all stimulus to be accepted and answered, then run a tail of idle
    // clocks to catch any stray response. The watchdog bounds both waits.
    while (pending_q.size() != 0 || offering || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("mosi_snoop_coherence_controller_top verification clean");
    end else begin
      $display("mosi_snoop_coherence_controller_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/msc_pkg.sv
hdl/msc_req_if.sv
hdl/msc_rsp_if.sv
hdl/msc_ram.sv
hdl/mosi_snoop_coherence_controller_top.sv
dv/tb.sv
